// ----- rtl/votl_pkg.sv -----
// Shared constants, register codes and inter-module types of the varint offset table lookup.
`timescale 1ns / 1ps
`default_nettype none
package votl_pkg;

	// Field and state widths
	localparam int DATA_W     = 8;
	localparam int VAL_W      = 32;
	localparam int MAX_GROUPS = 9;
	localparam int GRP_W      = 4;
	localparam int CNT_W      = 32;
	localparam int IDX_W      = 31;
	localparam int SKIP_W     = 8;
	localparam int IVL_W      = 16;
	localparam int OFS_W      = 49;
	localparam int OP_W       = 33;

	// Configuration port
	localparam int ADDR_W  = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_SKIP_COUNT = 2'd0;
	localparam logic [1:0] REG_TARGET     = 2'd1;
	localparam logic [1:0] REG_INTERVAL   = 2'd2;

	localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(1);

	// Live register values toward the scanner
	typedef struct packed {
		logic [SKIP_W-1:0]       skip_count;
		logic signed [VAL_W-1:0] target_position;
		logic [IVL_W-1:0]        interval;
		logic                    skip_wr;
	} cfg_t;

	// Pending result: signed multiplicand and the interval it is scaled by
	typedef struct packed {
		logic                   valid;
		logic signed [OP_W-1:0] op;
		logic [IVL_W-1:0]       ivl;
		logic                   matched;
	} emit_t;

endpackage
`default_nettype wire

// ----- rtl/votl_ifs.sv -----
// Valid/ready channel interfaces for record bytes and lookup results.
`timescale 1ns / 1ps
`default_nettype none
interface votl_in_if;
	logic                          valid;
	logic                          ready;
	logic [votl_pkg::DATA_W-1:0]   data_byte;
	logic                          last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface votl_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [votl_pkg::OFS_W-1:0]   result_offset;
	logic                                matched;

	modport source (output valid, output result_offset, output matched, input ready);
	modport sink (input valid, input result_offset, input matched, output ready);
endinterface
`default_nettype wire

// ----- rtl/votl_regs.sv -----
// APB-style configuration registers: skip count, target position, interval.
`timescale 1ns / 1ps
`default_nettype none
module votl_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [votl_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [votl_pkg::PDATA_W-1:0]    pwdata,
	output logic [votl_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	output votl_pkg::cfg_t                       cfg
);
	import votl_pkg::*;

	logic [SKIP_W-1:0]       skip_count_q;
	logic signed [VAL_W-1:0] target_q;
	logic [IVL_W-1:0]        interval_q;
	logic                    wr;
	logic                    skip_wr;
	logic [1:0]              reg_idx;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign skip_wr = wr && (reg_idx == REG_SKIP_COUNT);

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q <= '0;
			target_q     <= '0;
			interval_q   <= INTERVAL_RESET;
		end else if (wr) begin
			case (reg_idx)
				REG_SKIP_COUNT: skip_count_q <= pwdata[SKIP_W-1:0];
				REG_TARGET:     target_q     <= $signed(pwdata[VAL_W-1:0]);
				REG_INTERVAL:   interval_q   <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_SKIP_COUNT: prdata = PDATA_W'(skip_count_q);
			REG_TARGET:     prdata = PDATA_W'(target_q);
			REG_INTERVAL:   prdata = PDATA_W'(interval_q);
			default:        prdata = '0;
		endcase
	end

	// Pass a skip count being written straight through so the scanner reloads the new value
	assign cfg.skip_count      = skip_wr ? pwdata[SKIP_W-1:0] : skip_count_q;
	assign cfg.target_position = target_q;
	assign cfg.interval        = interval_q;
	assign cfg.skip_wr         = skip_wr;
endmodule
`default_nettype wire

// ----- rtl/votl_scan.sv -----
// Varint parser and table scan: one record byte per cycle while take is high, result operand into stage 2.
`timescale 1ns / 1ps
`default_nettype none
module votl_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire votl_pkg::cfg_t                cfg,
	input  wire logic                          take,
	input  wire logic [votl_pkg::DATA_W-1:0]   data_byte,
	input  wire logic                          last_byte,
	input  wire logic                          pop,
	output votl_pkg::emit_t                    emit
);
	import votl_pkg::*;

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_SCAN  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [1:0]        phase_q, phase_n, ph;
	logic [SKIP_W-1:0] skips_q, skips_n;
	logic [GRP_W-1:0]  grp_q, grp_n, grp_inc;
	logic [VAL_W-1:0]  acc_q, acc_n, acc_new, part;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [IDX_W-1:0]  idx_q, idx_n;
	logic              done, in_range;
	logic              em;
	logic signed [OP_W-1:0] op;
	logic              mt;

	logic                   emit_valid_s2;
	logic signed [OP_W-1:0] emit_op_s2;
	logic [IVL_W-1:0]       emit_ivl_s2;
	logic                   emit_matched_s2;

	// Place the 7 payload bits of this byte at its group position; group 4 keeps only the low 4, later groups none
	always_comb begin
		case (grp_q)
			GRP_W'(0): part = VAL_W'(data_byte[6:0]);
			GRP_W'(1): part = VAL_W'({data_byte[6:0], 7'b0});
			GRP_W'(2): part = VAL_W'({data_byte[6:0], 14'b0});
			GRP_W'(3): part = VAL_W'({data_byte[6:0], 21'b0});
			GRP_W'(4): part = {data_byte[3:0], 28'b0};
			default:   part = '0;
		endcase
	end

	assign acc_new  = acc_q | part;
	assign grp_inc  = grp_q + GRP_W'(1);
	assign done     = !data_byte[7] || (grp_inc >= GRP_W'(MAX_GROUPS)) || last_byte;
	assign in_range = !cnt_q[CNT_W-1] && ({1'b0, idx_q} < cnt_q);

	// Next state for one accepted byte
	always_comb begin
		ph = phase_q;
		if (ph == PH_SKIP && skips_q == '0) begin
			ph = PH_COUNT;
		end
		phase_n = phase_q;
		skips_n = skips_q;
		grp_n   = grp_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		idx_n   = idx_q;
		em      = 1'b0;
		op      = '0;
		mt      = 1'b0;
		if (take) begin
			phase_n = ph;
			case (ph)
				PH_SKIP: begin
					grp_n = done ? '0 : grp_inc;
					acc_n = done ? '0 : acc_new;
					if (done) begin
						skips_n = skips_q - SKIP_W'(1);
					end
					if (last_byte) begin
						em = 1'b1;
					end
				end
				PH_COUNT: begin
					grp_n = done ? '0 : grp_inc;
					acc_n = done ? '0 : acc_new;
					if (done) begin
						cnt_n   = acc_new;
						idx_n   = '0;
						phase_n = PH_SCAN;
					end
				end
				PH_SCAN: begin
					if (in_range) begin
						grp_n = done ? '0 : grp_inc;
						acc_n = done ? '0 : acc_new;
						if (done) begin
							if (cfg.interval != '0 &&
							    $signed(acc_new) >= cfg.target_position) begin
								em      = 1'b1;
								op      = $signed({2'b0, idx_q});
								mt      = 1'b1;
								phase_n = PH_DONE;
							end else begin
								idx_n = idx_q + IDX_W'(1);
							end
						end
					end
				end
				default: ;
			endcase
			// Record end: fall back to the last entry, then restart
			if (last_byte) begin
				if (!em && phase_n != PH_DONE) begin
					em = 1'b1;
					op = $signed({1'b0, cnt_n}) - OP_W'(1);
				end
				phase_n = PH_SKIP;
				skips_n = cfg.skip_count;
				grp_n   = '0;
				acc_n   = '0;
				cnt_n   = '0;
				idx_n   = '0;
			end
		end
		if (cfg.skip_wr) begin
			skips_n = cfg.skip_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			skips_q <= '0;
			grp_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_n;
			skips_q <= skips_n;
			grp_q   <= grp_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			idx_q   <= idx_n;
		end
	end

	// Hold the pending result until the output stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_valid_s2 <= 1'b0;
		end else if (take) begin
			emit_valid_s2 <= em;
		end else if (pop) begin
			emit_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && em) begin
			emit_op_s2      <= op;
			emit_ivl_s2     <= cfg.interval;
			emit_matched_s2 <= mt;
		end
	end

	assign emit.valid   = emit_valid_s2;
	assign emit.op      = emit_op_s2;
	assign emit.ivl     = emit_ivl_s2;
	assign emit.matched = emit_matched_s2;
endmodule
`default_nettype wire

// ----- rtl/varint_offset_table_lookup.sv -----
// Top level: configuration registers, varint scanner and scaled result output stage.
//
//   channel    dir  handshake        payload
//   byte_ch    in   valid / ready    data_byte[7:0], last_byte
//   result_ch  out  valid / ready    result_offset[48:0] (signed), matched
//   apb        in   psel / penable   paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One byte is accepted per cycle unless the output stalls; a result passes from the byte
// that causes it through the scan register, then the interval multiply into the output register.
// At most one result per record, given on the record's last byte or on the match.
// arst_n clears all control state; registers return to skip 0, target 0, interval 1.
// A result waiting at the output stalls input only when the scan register also holds one.
`timescale 1ns / 1ps
`default_nettype none
module varint_offset_table_lookup (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	votl_in_if.sink                              byte_ch,
	votl_out_if.source                           result_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [votl_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [votl_pkg::PDATA_W-1:0]    pwdata,
	output logic [votl_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);
	import votl_pkg::*;

	cfg_t  cfg;
	emit_t emit;
	logic  out_free, pop, take;
	logic  out_valid_q;
	logic signed [OFS_W-1:0] offset_q;
	logic  matched_q;
	logic signed [OP_W+IVL_W:0] prod;

	votl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage handshakes
	assign out_free       = !out_valid_q || result_ch.ready;
	assign pop            = emit.valid && out_free;
	assign byte_ch.ready  = !emit.valid || out_free;
	assign take           = byte_ch.valid && byte_ch.ready;

	votl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.data_byte (byte_ch.data_byte),
		.last_byte (byte_ch.last_byte),
		.pop       (pop),
		.emit      (emit)
	);

	// Scale by the interval
	assign prod = emit.op * $signed({1'b0, emit.ivl});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			offset_q  <= prod[OFS_W-1:0];
			matched_q <= emit.matched;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.result_offset = offset_q;
	assign result_ch.matched       = matched_q;

`ifndef NO_ASSERTIONS
	a_match_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.matched) |-> !result_ch.result_offset[OFS_W-1])
		else $error("matched result has a negative offset");

	a_match_ivl: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.matched) |-> (emit.ivl != '0))
		else $error("match recorded with zero interval");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && out_valid_q && !result_ch.ready) |-> !byte_ch.ready)
		else $error("byte accepted with both result stages full");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit.valid))
		else $error("result appeared without a pending scan result");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_varint_offset_table_lookup.sv -----
// Self-checking testbench for the varint offset table lookup: record streams, APB setup, scoreboard.
`timescale 1ns / 1ps
module tb_varint_offset_table_lookup;
	import votl_pkg::*;

	typedef enum logic [1:0] {ST_SKIP, ST_COUNT, ST_ENTRIES, ST_DONE} scan_phase_t;

	typedef struct {
		logic signed [OFS_W-1:0] offset;
		logic                    matched;
	} lookup_result_t;

	// Scoreboard: tracks the record scan and queues the offsets it should produce
	class offset_scoreboard;
		logic [SKIP_W-1:0]       skip_cfg;
		logic signed [VAL_W-1:0] target_cfg;
		logic [IVL_W-1:0]        interval_cfg;

		scan_phase_t       phase;
		logic [SKIP_W-1:0] skips_left;
		logic [GRP_W-1:0]  group_index;
		logic [VAL_W-1:0]  value_acc;
		logic [CNT_W-1:0]  entry_count;
		logic [31:0]       entry_index;

		lookup_result_t pending_offsets[$];
		int failures;
		int results_seen;
		int matches_seen;

		function new();
			skip_cfg = '0;
			target_cfg = '0;
			interval_cfg = INTERVAL_RESET;
			failures = 0;
			results_seen = 0;
			matches_seen = 0;
			restart_record();
		endfunction

		function void restart_record();
			phase = ST_SKIP;
			skips_left = skip_cfg;
			group_index = '0;
			value_acc = '0;
			entry_count = '0;
			entry_index = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_SKIP_COUNT: begin
					skip_cfg = value[SKIP_W-1:0];
					skips_left = skip_cfg;
				end
				REG_TARGET: target_cfg = value[VAL_W-1:0];
				REG_INTERVAL: interval_cfg = value[IVL_W-1:0];
				default: ;
			endcase
		endfunction

		// Fold one 7-bit group into the varint; return 1 when the varint closes
		function bit absorb_group(logic [7:0] b, bit last);
			logic [63:0] wide;
			int shift;
			shift = 7 * group_index;
			wide = {32'd0, value_acc} | (64'(b[6:0]) << shift);
			value_acc = wide[VAL_W-1:0];
			group_index = group_index + 1'b1;
			if (!b[7] || group_index >= MAX_GROUPS || last) begin
				group_index = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Advance the scan by one accepted word and queue any offset it yields
		function void note_byte(logic [7:0] b, bit last);
			lookup_result_t res;
			bit emit;
			logic [63:0] product;
			logic signed [VAL_W-1:0] entry_value;
			longint bound;
			longint idx_wide;
			emit = 1'b0;
			res.offset = '0;
			res.matched = 1'b0;
			if (phase == ST_SKIP && skips_left == 0)
				phase = ST_COUNT;
			case (phase)
				ST_SKIP: begin
					if (absorb_group(b, last)) begin
						value_acc = '0;
						skips_left = skips_left - 1'b1;
					end
					if (last)
						emit = 1'b1;
				end
				ST_COUNT: begin
					if (absorb_group(b, last)) begin
						entry_count = value_acc;
						value_acc = '0;
						entry_index = '0;
						phase = ST_ENTRIES;
					end
				end
				ST_ENTRIES: begin
					bound = longint'($signed(entry_count));
					idx_wide = longint'({32'd0, entry_index});
					if (idx_wide < bound && absorb_group(b, last)) begin
						entry_value = value_acc;
						value_acc = '0;
						if (interval_cfg != 0 && entry_value >= target_cfg) begin
							product = 64'(entry_index) * 64'(interval_cfg);
							res.offset = product[OFS_W-1:0];
							res.matched = 1'b1;
							emit = 1'b1;
							phase = ST_DONE;
						end else begin
							entry_index = entry_index + 1;
						end
					end
				end
				default: ;
			endcase
			// Record end: fall back to the last entry unless something was emitted
			if (last) begin
				if (!emit && phase != ST_DONE) begin
					product = (64'(entry_count) - 64'd1) * 64'(interval_cfg);
					res.offset = (interval_cfg == 0) ? '0 : product[OFS_W-1:0];
					res.matched = 1'b0;
					emit = 1'b1;
				end
				restart_record();
			end
			if (emit)
				pending_offsets.push_back(res);
		endfunction

		function void flag(string what);
			failures++;
			if (failures <= 10)
				$display("[%0t] ERROR %s", $time, what);
		endfunction

		// Compare one delivered offset with the oldest queued one
		function void check_result(logic signed [OFS_W-1:0] offset, logic matched);
			lookup_result_t want;
			results_seen++;
			if (matched === 1'b1)
				matches_seen++;
			if (pending_offsets.size() == 0) begin
				flag($sformatf("unexpected result offset=%0d matched=%b", offset, matched));
				return;
			end
			want = pending_offsets.pop_front();
			if (offset !== want.offset)
				flag($sformatf("result_offset expected %0d got %0d", want.offset, offset));
			if (matched !== want.matched)
				flag($sformatf("matched expected %b got %b", want.matched, matched));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	votl_in_if byte_if ();
	votl_out_if res_if ();

	varint_offset_table_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (res_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	offset_scoreboard sb = new();

	logic [7:0] record_bytes[$];
	int idle_pct = 22;
	int records_sent = 0;
	int bytes_sent = 0;
	int random_bytes = 0;
	int settings_used = 0;
	logic [SKIP_W-1:0] cur_skip = '0;
	logic signed [VAL_W-1:0] cur_target = '0;
	logic [IVL_W-1:0] cur_ivl = INTERVAL_RESET;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result sink: stall at random, sample at the rising edge
	initial res_if.ready = 1'b0;
	always @(negedge clk)
		res_if.ready <= ($urandom_range(0, 99) >= idle_pct);

	always @(posedge clk)
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
			sb.check_result(res_if.result_offset, res_if.matched);

	// Offer one word; hold valid high afterwards for the next one
	task automatic send_byte(logic [7:0] b, bit last);
		while ($urandom_range(0, 99) < idle_pct) begin
			byte_if.valid <= 1'b0;
			@(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.last_byte <= last;
		do @(posedge clk); while (byte_if.ready !== 1'b1);
		sb.note_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_record();
		for (int i = 0; i < record_bytes.size(); i++)
			send_byte(record_bytes[i], i == record_bytes.size() - 1);
		records_sent++;
	endtask

	task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain all results, let the pipeline settle, then reprogram every register
	task automatic apply_settings(logic [SKIP_W-1:0] skip, logic signed [VAL_W-1:0] target,
			logic [IVL_W-1:0] ivl);
		byte_if.valid <= 1'b0;
		while (sb.pending_offsets.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		apb_write(REG_SKIP_COUNT, PDATA_W'(skip));
		apb_write(REG_TARGET, PDATA_W'(target));
		apb_write(REG_INTERVAL, PDATA_W'(ivl));
		cur_skip = skip;
		cur_target = target;
		cur_ivl = ivl;
		settings_used++;
	endtask

	// Append a varint, sometimes overlong, with junk in groups past bit 31
	task automatic push_varint(logic [31:0] value);
		int min_len;
		int len;
		int i;
		logic [7:0] b;
		min_len = 1;
		for (i = 1; i < 5; i++)
			if ((value >> (7 * i)) != 0)
				min_len = i + 1;
		len = ($urandom_range(0, 99) < 75) ? min_len : $urandom_range(min_len, MAX_GROUPS);
		for (i = 0; i < len; i++) begin
			b = '0;
			if (i < 5)
				b[6:0] = 7'(value >> (7 * i));
			if (i == 4 && $urandom_range(0, 1))
				b[6:4] = 3'($urandom);
			if (i > 4 && $urandom_range(0, 1))
				b[6:0] = 7'($urandom);
			if (i < len - 1)
				b[7] = 1'b1;
			else
				b[7] = (len == MAX_GROUPS) ? 1'($urandom) : 1'b0;
			record_bytes.push_back(b);
		end
	endtask

	function automatic logic [31:0] pick_entry();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return cur_target + 32'($urandom_range(0, 4)) - 32'd2;
		if (r < 70)
			return cur_target - 32'($urandom_range(1, 1000));
		return $urandom;
	endfunction

	// Build one record: mostly well-formed, some noise, some cut short
	task automatic random_record();
		int mode;
		int r;
		int n;
		logic [31:0] count;
		record_bytes.delete();
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			n = $urandom_range(1, 12);
			repeat (n) record_bytes.push_back(8'($urandom));
		end else begin
			// Long skips use one-byte varints to keep the record short
			if (cur_skip > 16)
				repeat (cur_skip) record_bytes.push_back(8'($urandom_range(0, 127)));
			else
				repeat (cur_skip)
					push_varint(($urandom_range(0, 99) < 80) ? 32'($urandom_range(0, 127)) : $urandom);
			r = $urandom_range(0, 99);
			if (r < 10)
				count = '0;
			else if (r < 18)
				count = {1'b1, 31'($urandom)};
			else if (r < 26)
				count = $urandom;
			else
				count = $urandom_range(1, 6);
			push_varint(count);
			n = $urandom_range(0, 7);
			repeat (n) push_varint(pick_entry());
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom));
			// Cut the record anywhere, often inside a varint
			if (mode < 16)
				record_bytes = record_bytes[0:$urandom_range(0, record_bytes.size() - 1)];
		end
		random_bytes += record_bytes.size();
		send_record();
	endtask

	initial begin
		int phase_idx;
		int nrec;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.last_byte = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero count, match after a negative entry with trailing words,
		// count with top bit set, zero interval, end inside skip, fallback past all entries
		record_bytes = '{8'h00};
		send_record();
		record_bytes = '{8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h05, 8'hff, 8'h80};
		send_record();
		record_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h08, 8'h05};
		send_record();
		apply_settings(8'd0, 32'sd0, 16'd0);
		record_bytes = '{8'h01, 8'h05};
		send_record();
		apply_settings(8'd2, 32'sh7fffffff, 16'hffff);
		record_bytes = '{8'h01};
		send_record();
		record_bytes = '{8'h81, 8'h01, 8'h00, 8'h03, 8'h7f};
		send_record();

		// Random phases, extremes of every register first
		phase_idx = 0;
		while (random_bytes < 550 || phase_idx < 6) begin
			case (phase_idx)
				0: apply_settings(8'd0, 32'sd0, 16'd1);
				1: apply_settings(8'd255, 32'sh80000000, 16'hffff);
				2: apply_settings(8'd1, 32'sh7fffffff, 16'd0);
				3: apply_settings(8'd0, 32'sh80000000, 16'hffff);
				default: apply_settings(
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40)) : 8'($urandom_range(0, 4)),
					$urandom_range(0, 1) ? 32'($urandom_range(0, 100)) - 32'sd50 : 32'($urandom),
					($urandom_range(0, 9) == 0) ? 16'd0 :
					($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom));
			endcase
			// Run phase 3 back to back on both sides, the other phases with random idles
			idle_pct = (phase_idx == 3) ? 0 : 22;
			nrec = (cur_skip > 16) ? 1 : (phase_idx == 3) ? 6 : $urandom_range(2, 4);
			repeat (nrec) random_record();
			phase_idx++;
		end

		byte_if.valid <= 1'b0;
		while (sb.pending_offsets.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.pending_offsets.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.pending_offsets.size()));

		$display("Sent %0d records (%0d words) over %0d register settings;",
			records_sent, bytes_sent, settings_used);
		$display("checked %0d results, %0d of them entry matches, %0d errors.",
			sb.results_seen, sb.matches_seen, sb.failures);
		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- varint_offset_table_lookup.f -----
rtl/votl_pkg.sv
rtl/votl_ifs.sv
rtl/votl_regs.sv
rtl/votl_scan.sv
rtl/varint_offset_table_lookup.sv
tb/tb_varint_offset_table_lookup.sv
